>>> rtl/core/qcsu_pkg.sv
// ----------------------------------------------------------------------------
// qcsu_pkg
// Shared types and constants of the quasi-cyclic syndrome update block.
// ----------------------------------------------------------------------------
`default_nettype none

package qcsu_pkg;

  localparam int unsigned OFF_W     = 12;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned WGT_W     = 13;
  localparam int unsigned BLEN_W    = 13;
  localparam int unsigned CWT_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 13;

  localparam int unsigned MOD_CNT_W = 4;
  localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(OFF_W - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef struct packed {
    logic              done;
    logic [BLEN_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/qcsu_ram.sv
// ----------------------------------------------------------------------------
// qcsu_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qcsu_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 128
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/qcsu_mod.sv
// ----------------------------------------------------------------------------
// qcsu_mod
// Bit-serial remainder unit: reduces a table position modulo the block length.
// ----------------------------------------------------------------------------
`default_nettype none

module qcsu_mod (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire [qcsu_pkg::OFF_W-1:0]        num_i,
  input  wire [qcsu_pkg::BLEN_W-1:0]       den_i,
  output qcsu_pkg::mod_rsp_t               rsp_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [qcsu_pkg::MOD_CNT_W-1:0]   cnt_q, cnt_d;
  logic [qcsu_pkg::OFF_W-1:0]       sh_q, sh_d;
  logic [qcsu_pkg::BLEN_W-1:0]      r_q, r_d;
  logic [qcsu_pkg::BLEN_W:0]        trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    r_d    = r_q;
    trial  = {r_q, sh_q[qcsu_pkg::OFF_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = num_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        r_d = qcsu_pkg::BLEN_W'(trial - {1'b0, den_i});
      end else begin
        r_d = qcsu_pkg::BLEN_W'(trial);
      end
      sh_d  = {sh_q[qcsu_pkg::OFF_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == qcsu_pkg::MOD_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    r_q  <= r_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;

endmodule

`default_nettype wire

>>> rtl/core/quasi_cyclic_syndrome_update.sv
// ----------------------------------------------------------------------------
// quasi_cyclic_syndrome_update
// Syndrome update for quasi-cyclic codes with a stored column table.
//
// One input transaction on the s_axis side yields exactly one result on the
// m_axis side. The input is taken only while the block is idle; a result
// that waits on a stalled receiver sits in the output register while the
// next transaction is already accepted and worked on.
// Work per transaction, from accept to result valid:
//   load, out-of-range offset : straight on to the result
//   read      : the syndrome bit at offset is read, then the result
//   add error : one syndrome bit flipped for each of the column_weight table
//               entries (none for a column weight of zero); an entry not
//               below block_length is first reduced by the bit-serial
//               remainder unit; one table read and one syndrome read-modify-
//               write per cycle otherwise, set by the single syndrome memory write port
//   clear     : one syndrome entry zeroed per cycle
// After reset the syndrome memory is swept to zero; s_axis_tready stays low
// during that pass, configuration writes are taken.
// Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module quasi_cyclic_syndrome_update #(
  parameter int unsigned MAX_BLOCK_LEN  = 4096,
  parameter int unsigned NUM_BLOCKS     = 2,
  parameter int unsigned MAX_COL_WEIGHT = 64
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [qcsu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [qcsu_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [23:0]                        s_axis_tdata,  // slot, offset, zero pad
  input  wire [2:0]                         s_axis_tuser,  // action, block_sel
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [15:0]                       m_axis_tdata,  // syndrome_weight, syndrome_bit, pad
  output logic [0:0]                        m_axis_tuser   // bad_position
);

  localparam int unsigned SA = $clog2(MAX_BLOCK_LEN);
  localparam int unsigned TA = $clog2(NUM_BLOCKS * MAX_COL_WEIGHT);
  localparam logic [SA-1:0] SWEEP_LAST = SA'(MAX_BLOCK_LEN - 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_FLIP  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]                       state_q, state_d;
  logic [qcsu_pkg::BLEN_W-1:0]      blen_q;
  logic [qcsu_pkg::CWT_W-1:0]       cwt_q;
  logic [qcsu_pkg::WGT_W-1:0]       weight_q, weight_d;
  logic [SA-1:0]                    sweep_q, sweep_d;
  logic [qcsu_pkg::CWT_W-1:0]       l_q, l_d;
  logic [qcsu_pkg::CWT_W-1:0]       w_q, w_d;
  logic                             tv_q, tv_d;
  logic                             mod_run_q, mod_run_d;
  logic                             s2_vld_q, s2_vld_d;
  logic                             fwd_vld_q, fwd_vld_d;
  logic                             out_vld_q, out_vld_d;

  logic [SA-1:0]                    s2_idx_q;
  logic [SA-1:0]                    fwd_idx_q;
  logic                             fwd_bit_q;
  logic [qcsu_pkg::OFF_W-1:0]       off_q;
  logic                             blk_q;
  logic                             bit_q, bit_d;
  logic                             bad_q, bad_d;
  logic [qcsu_pkg::WGT_W-1:0]       out_wgt_q;
  logic                             out_bit_q;
  logic                             out_bad_q;

  qcsu_pkg::action_e                in_act;
  logic                             in_blk;
  logic [qcsu_pkg::SLOT_W-1:0]      in_slot;
  logic [qcsu_pkg::OFF_W-1:0]       in_off;
  logic                             accept;
  logic                             in_bad;

  logic [qcsu_pkg::BLEN_W-1:0]      p_eff;
  logic [qcsu_pkg::CWT_W-1:0]       w_eff;

  logic                             tbl_we;
  logic [TA-1:0]                    tbl_waddr;
  logic                             tbl_re;
  logic [TA-1:0]                    tbl_raddr;
  logic [qcsu_pkg::OFF_W-1:0]       tbl_rdata;

  logic                             syn_we;
  logic [SA-1:0]                    syn_waddr;
  logic                             syn_wdata;
  logic                             syn_re;
  logic [SA-1:0]                    syn_raddr;
  logic                             syn_rdata;

  logic                             fetch_all;
  logic                             fetch;
  logic                             h_small;
  logic                             mod_start;
  qcsu_pkg::mod_rsp_t               mod_rsp;
  logic                             s1_go;
  logic [qcsu_pkg::BLEN_W-1:0]      h_red;
  logic [qcsu_pkg::BLEN_W:0]        h_sum;
  logic [SA-1:0]                    s1_idx;
  logic                             old_bit;
  logic                             new_bit;

  assign in_act  = qcsu_pkg::action_e'(s_axis_tuser[1:0]);
  assign in_blk  = s_axis_tuser[2];
  assign in_slot = s_axis_tdata[5:0];
  assign in_off  = s_axis_tdata[17:6];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (blen_q < qcsu_pkg::BLEN_W'(2)) begin
      p_eff = qcsu_pkg::BLEN_W'(2);
    end else if (32'(blen_q) > MAX_BLOCK_LEN) begin
      p_eff = qcsu_pkg::BLEN_W'(MAX_BLOCK_LEN);
    end else begin
      p_eff = blen_q;
    end
    if (32'(cwt_q) > MAX_COL_WEIGHT) begin
      w_eff = qcsu_pkg::CWT_W'(MAX_COL_WEIGHT);
    end else begin
      w_eff = cwt_q;
    end
  end

  assign in_bad = ({1'b0, in_off} >= p_eff);

  // column table
  assign tbl_we    = accept && (in_act == qcsu_pkg::ACT_LOAD) && !in_bad
                     && (32'(in_slot) < MAX_COL_WEIGHT);
  assign tbl_waddr = TA'(32'(in_blk) * MAX_COL_WEIGHT + 32'(in_slot));
  assign tbl_raddr = TA'(32'(blk_q) * MAX_COL_WEIGHT + 32'(l_q));
  assign tbl_re    = fetch;

  qcsu_ram #(
    .WIDTH (qcsu_pkg::OFF_W),
    .DEPTH (NUM_BLOCKS * MAX_COL_WEIGHT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (in_off),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // flip pipeline: fetch entry, reduce and index, read-modify-write bit
  assign fetch_all = (l_q == w_q);
  assign h_small   = ({1'b0, tbl_rdata} < p_eff);
  assign s1_go     = tv_q && (h_small || mod_rsp.done);
  assign fetch     = (state_q == ST_FLIP) && !fetch_all && (!tv_q || s1_go);
  assign mod_start = tv_q && !h_small && !mod_run_q;

  qcsu_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (tbl_rdata),
    .den_i   (p_eff),
    .rsp_o   (mod_rsp)
  );

  always_comb begin
    h_red = h_small ? {1'b0, tbl_rdata} : mod_rsp.rem;
    h_sum = {1'b0, qcsu_pkg::BLEN_W'(off_q)} + {1'b0, h_red};
    if (h_sum >= {1'b0, p_eff}) begin
      s1_idx = SA'(h_sum - {1'b0, p_eff});
    end else begin
      s1_idx = SA'(h_sum);
    end
  end

  assign old_bit = (fwd_vld_q && (fwd_idx_q == s2_idx_q)) ? fwd_bit_q : syn_rdata;
  assign new_bit = ~old_bit;

  // syndrome memory
  always_comb begin
    if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
      syn_we    = 1'b1;
      syn_waddr = sweep_q;
      syn_wdata = 1'b0;
    end else begin
      syn_we    = s2_vld_q;
      syn_waddr = s2_idx_q;
      syn_wdata = new_bit;
    end
    if (state_q == ST_IDLE) begin
      syn_re    = accept && (in_act == qcsu_pkg::ACT_READ) && !in_bad;
      syn_raddr = SA'(in_off);
    end else begin
      syn_re    = s1_go;
      syn_raddr = s1_idx;
    end
  end

  qcsu_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLOCK_LEN)
  ) u_syndrome (
    .clk_i   (clk_i),
    .we_i    (syn_we),
    .waddr_i (syn_waddr),
    .wdata_i (syn_wdata),
    .re_i    (syn_re),
    .raddr_i (syn_raddr),
    .rdata_o (syn_rdata)
  );

  // control
  always_comb begin
    state_d   = state_q;
    weight_d  = weight_q;
    sweep_d   = sweep_q;
    l_d       = l_q;
    w_d       = w_q;
    tv_d      = tv_q;
    mod_run_d = mod_run_q;
    s2_vld_d  = 1'b0;
    fwd_vld_d = fwd_vld_q;
    bit_d     = bit_q;
    bad_d     = bad_q;
    out_vld_d = out_vld_q && !m_axis_tready;

    if (mod_start) begin
      mod_run_d = 1'b1;
    end else if (mod_rsp.done) begin
      mod_run_d = 1'b0;
    end
    if (fetch) begin
      l_d  = l_q + 1'b1;
      tv_d = 1'b1;
    end else if (s1_go) begin
      tv_d = 1'b0;
    end
    if (s1_go) begin
      s2_vld_d = 1'b1;
    end
    if (s2_vld_q) begin
      fwd_vld_d = 1'b1;
      weight_d  = new_bit ? weight_q + 1'b1 : weight_q - 1'b1;
    end

    case (state_q)
      ST_INIT, ST_CLEAR: begin
        fwd_vld_d = 1'b0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == SWEEP_LAST) begin
          sweep_d  = '0;
          weight_d = '0;
          state_d  = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          bit_d = 1'b0;
          bad_d = 1'b0;
          if (in_act == qcsu_pkg::ACT_CLEAR) begin
            sweep_d = '0;
            state_d = ST_CLEAR;
          end else if (in_bad) begin
            bad_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            case (in_act)
              qcsu_pkg::ACT_ADD: begin
                l_d     = '0;
                w_d     = w_eff;
                state_d = (w_eff == '0) ? ST_DONE : ST_FLIP;
              end
              qcsu_pkg::ACT_READ: begin
                state_d = ST_READ;
              end
              default: begin
                state_d = ST_DONE;
              end
            endcase
          end
        end
      end
      ST_FLIP: begin
        if (fetch_all && !tv_q && !s2_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        bit_d   = syn_rdata;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      blen_q    <= qcsu_pkg::BLEN_W'(4096);
      cwt_q     <= qcsu_pkg::CWT_W'(64);
      weight_q  <= '0;
      sweep_q   <= '0;
      l_q       <= '0;
      w_q       <= '0;
      tv_q      <= 1'b0;
      mod_run_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      weight_q  <= weight_d;
      sweep_q   <= sweep_d;
      l_q       <= l_d;
      w_q       <= w_d;
      tv_q      <= tv_d;
      mod_run_q <= mod_run_d;
      s2_vld_q  <= s2_vld_d;
      fwd_vld_q <= fwd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == qcsu_pkg::CFG_BLOCK_LENGTH) begin
          blen_q <= cfg_data_i;
        end else begin
          cwt_q <= cfg_data_i[qcsu_pkg::CWT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q <= bit_d;
    bad_q <= bad_d;
    if (s1_go) begin
      s2_idx_q <= s1_idx;
    end
    if (s2_vld_q) begin
      fwd_idx_q <= s2_idx_q;
      fwd_bit_q <= new_bit;
    end
    if (accept) begin
      off_q <= in_off;
      blk_q <= in_blk;
    end
    if ((state_q == ST_DONE) && (!out_vld_q || m_axis_tready)) begin
      out_wgt_q <= weight_q;
      out_bit_q <= bit_q;
      out_bad_q <= bad_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_bit_q, out_wgt_q};
  assign m_axis_tuser  = out_bad_q;

endmodule

`default_nettype wire
